>>> src/cwd_pkg.sv
package cwd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'h00;

  localparam logic [2:0] PosFirstCrc  = 3'd2;
  localparam logic [2:0] PosSecondCrc = 3'd5;
  localparam logic [2:0] PosStart     = 3'd0;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word_value;
    logic        check_status;
  } out_item_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> src/cwd_stream_if.sv
interface cwd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/cwd_deframe_core.sv
module cwd_deframe_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cwd_pkg::in_item_t item_i,
  input  logic              long_word_mode_i,
  output logic              final_o,
  output cwd_pkg::out_item_t result_o
);
  import cwd_pkg::*;

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d, crc_base;
  logic [31:0] acc_q, acc_d, acc_base;
  logic        mis_q, mis_d, mis_base, mis_now;
  logic        is_crc;

  always_comb begin
    pos      = item_i.first_byte ? PosStart : pos_q;
    crc_base = item_i.first_byte ? CrcInit : crc_q;
    acc_base = item_i.first_byte ? 32'd0 : acc_q;
    mis_base = item_i.first_byte ? 1'b0 : mis_q;
    if (pos > PosSecondCrc) begin
      pos = PosStart;
    end

    is_crc  = (pos == PosFirstCrc) || (pos == PosSecondCrc);
    mis_now = mis_base | (is_crc && (crc_base != item_i.rx_byte));
    final_o = is_crc && ((pos == PosSecondCrc) || !long_word_mode_i);

    result_o.word_value   = mis_now ? 32'd0 : acc_base;
    result_o.check_status = mis_now;

    if (final_o) begin
      pos_d = PosStart;
      crc_d = CrcInit;
      acc_d = 32'd0;
      mis_d = 1'b0;
    end else if (is_crc) begin
      pos_d = pos + 3'd1;
      crc_d = CrcInit;
      acc_d = acc_base;
      mis_d = mis_now;
    end else begin
      pos_d = pos + 3'd1;
      crc_d = crc8_update(crc_base, item_i.rx_byte);
      acc_d = {acc_base[23:0], item_i.rx_byte};
      mis_d = mis_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosStart;
      crc_q <= CrcInit;
      acc_q <= 32'd0;
      mis_q <= 1'b0;
    end else if (step_i) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      acc_q <= acc_d;
      mis_q <= mis_d;
    end
  end

endmodule

>>> src/cwd_out_reg.sv
module cwd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  cwd_pkg::out_item_t result_i,
  output logic               slot_free_o,
  cwd_stream_if.source       out_if
);
  import cwd_pkg::*;

  logic      valid_q;
  out_item_t data_q;

  assign slot_free_o    = !valid_q || out_if.ready;
  assign out_if.valid   = valid_q;
  assign out_if.payload = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

>>> src/crc_checked_word_deframer.sv
// CRC-checked word deframer.
// rx_if (sink) takes one byte of a sensor read per transfer: rx_byte and
// first_byte, which restarts the byte count. Bytes come as two data bytes
// and a CRC-8 (poly 0x31, init 0x00) per group; long_word_mode selects one
// group (16-bit value) or two groups (32-bit value). The user must write it
// through long_word_mode_we_i / long_word_mode_i while the block is idle;
// the block does not enforce this. res_if (source) gives one transfer per
// read: word_value, MSB first, and check_status (1 = some CRC failed, value
// then zero). A byte is checked while it sits in the input register after
// its transfer; a final byte loads the output register, which offers the
// result. Throughput: one byte per cycle while no final byte waits on a
// stalled res_if; the CRC update is combinational.
// When res_if stalls, the output register holds its result; bytes that end
// no read keep flowing, and a final byte waits in the input register.
// Reset clears the mode to 16-bit, the byte count, CRC and both valid flags.
module crc_checked_word_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         long_word_mode_we_i,
  input  logic         long_word_mode_i,
  cwd_stream_if.sink   rx_if,
  cwd_stream_if.source res_if
);
  import cwd_pkg::*;

  logic      mode_q;
  logic      in_valid_q;
  in_item_t  in_data_q;
  logic      step;
  logic      final_byte;
  logic      slot_free;
  out_item_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (long_word_mode_we_i) begin
      mode_q <= long_word_mode_i;
    end
  end

  assign step        = in_valid_q && (!final_byte || slot_free);
  assign rx_if.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_if.ready) begin
      in_valid_q <= rx_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_if.valid && rx_if.ready) begin
      in_data_q <= rx_if.payload;
    end
  end

  cwd_deframe_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .item_i          (in_data_q),
    .long_word_mode_i(mode_q),
    .final_o         (final_byte),
    .result_o        (result)
  );

  cwd_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && final_byte),
    .result_i   (result),
    .slot_free_o(slot_free),
    .out_if     (res_if)
  );

  a_final_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && final_byte |=> res_if.valid)
    else $error("final byte did not load a result");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid && res_if.payload.check_status |-> res_if.payload.word_value == 32'd0)
    else $error("error result carries a nonzero value");

  a_stall_holds_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_data_q))
    else $error("stalled byte was lost");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> rx_if.ready)
    else $error("input not ready while input register empty");

endmodule
